FILE: hdl/rna_pkg.sv
// Package for the rational accumulator: widths, operation codes and shared types.
// No dependencies.
package rna_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned DW    = 64;

  localparam logic [2:0] KIND_LOAD = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_SUB  = 3'd2;
  localparam logic [2:0] KIND_MUL  = 3'd3;
  localparam logic [2:0] KIND_DIV  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] operand_numerator;
    logic [31:0] operand_denominator;
  } req_t;

  typedef struct packed {
    logic [31:0] result_numerator;
    logic [30:0] result_denominator;
    logic        bad_denominator;
    logic        overflow;
  } rsp_t;

  // Control and status between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: hdl/rna_if.sv
// Valid/ready channel interface for requests and results.
// Depends on rna_pkg.
interface rna_req_if import rna_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rna_rsp_if import rna_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/rna_divider.sv
// Restoring divider, one quotient bit per cycle, over DW-bit unsigned values.
// Depends on rna_pkg.
module rna_divider import rna_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  div_ctl_t      ctl_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output div_sts_t      sts_o,
  output logic [DW-1:0] quotient_o,
  output logic [DW-1:0] remainder_o
);

  logic [DW-1:0]         quo_q, quo_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [$clog2(DW):0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [DW:0]           shifted;
  logic [DW:0]           trial;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    trial   = shifted - {1'b0, dsr_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (ctl_i.start) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DW]) begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(DW)+1)'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign sts_o.busy   = busy_q;
  assign sts_o.done   = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) sts_o.done |-> !sts_o.busy)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl_i.start |=> sts_o.busy)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) sts_o.done |-> $past(sts_o.busy))
    else $error("divider done without work");

endmodule

FILE: hdl/rational_number_alu_core.sv
// Rational accumulator core: operation sequencer with one shared 32x32 multiplier
// and one shared iterative divider. Depends on rna_pkg, rna_if and rna_divider.
// Each request runs the multiplier steps, then Euclid's algorithm on the divider, then two
// divisions by the gcd. A zero numerator skips the divider and an undefined kind goes
// straight to the result. One request at a time: ready again the cycle after the result.
// Reset: the held fraction becomes 0/1 and the block is ready at once.
module rational_number_alu_core import rna_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  rna_req_if.sink   req_i,
  rna_rsp_if.source rsp_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_COMB  = 4'd2;
  localparam logic [3:0] ST_GCD   = 4'd3;
  localparam logic [3:0] ST_GWAIT = 4'd4;
  localparam logic [3:0] ST_QN    = 4'd5;
  localparam logic [3:0] ST_QNW   = 4'd6;
  localparam logic [3:0] ST_QDW   = 4'd7;
  localparam logic [3:0] ST_FIT   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]      state_q, state_d;
  logic [1:0]      mstep_q, mstep_d;
  logic [2:0]      kind_q;
  logic [31:0]     on_q, od_q;
  logic            os_q, bad_q, bad_d, ovf_q, ovf_d;
  logic [DW-1:0]   p0_q, p1_q, p_d;
  logic [DW-1:0]   nm_q, nm_d, dm_q, dm_d, ga_q, ga_d, gb_q, gb_d;
  logic            ns_q, ns_d;
  logic [WIDTH-1:0] accn_q, accn_d;
  logic [WIDTH-1:0] accd_q, accd_d;
  logic [31:0]     ma, mb;
  logic [DW-1:0]   prod;
  logic            as;
  logic [31:0]     am, ad;
  div_ctl_t        dctl;
  div_sts_t        dsts;
  logic [DW-1:0]   ddvd, ddvs, dq, dr;
  logic [31:0]     rn_mag, rd_mag;
  logic            rn_neg, rd_neg, rd_zero;
  logic [DW-1:0]   half;
  logic            fits;

  rna_divider u_div (
    .clk_i, .rst_ni, .ctl_i(dctl), .dividend_i(ddvd), .divisor_i(ddvs),
    .sts_o(dsts), .quotient_o(dq), .remainder_o(dr)
  );

  assign as   = accn_q[WIDTH-1];
  assign am   = 32'(as ? -{{(32-WIDTH){1'b1}}, accn_q} : {{(32-WIDTH){1'b0}}, accn_q});
  assign ad   = 32'(accd_q);
  assign prod = {32'd0, ma} * {32'd0, mb};
  assign half = DW'(1) << (WIDTH - 1);

  always_comb begin
    rn_neg  = req_i.data.operand_numerator[31];
    rn_mag  = rn_neg ? -req_i.data.operand_numerator : req_i.data.operand_numerator;
    rd_neg  = req_i.data.operand_denominator[31];
    rd_mag  = rd_neg ? -req_i.data.operand_denominator : req_i.data.operand_denominator;
    rd_zero = (req_i.data.operand_denominator == 32'd0);
  end

  // Multiplier operands: step 0 gives am*od (or am*on), step 1 on*ad, step 2 ad*od.
  always_comb begin
    ma = am;
    mb = od_q;
    case (mstep_q)
      2'd0: begin
        ma = am;
        mb = (kind_q == KIND_MUL) ? on_q : od_q;
      end
      2'd1: begin
        ma = (kind_q == KIND_DIV) ? ad : on_q;
        mb = (kind_q == KIND_DIV) ? on_q : ad;
      end
      default: begin
        ma = ad;
        mb = od_q;
      end
    endcase
  end

  always_comb begin
    fits = (dm_q <= half - 1) && (ns_q ? (nm_q <= half) : (nm_q <= half - 1));
  end

  always_comb begin
    state_d = state_q;
    mstep_d = mstep_q;
    bad_d   = bad_q;
    ovf_d   = ovf_q;
    nm_d    = nm_q;
    dm_d    = dm_q;
    ns_d    = ns_q;
    ga_d    = ga_q;
    gb_d    = gb_q;
    accn_d  = accn_q;
    accd_d  = accd_q;
    p_d     = prod;
    dctl.start = 1'b0;
    ddvd    = ga_q;
    ddvs    = gb_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          bad_d   = rd_zero && (req_i.data.kind <= KIND_DIV);
          ovf_d   = 1'b0;
          mstep_d = 2'd0;
          state_d = (req_i.data.kind <= KIND_DIV) ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: begin
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd2) state_d = ST_COMB;
      end
      ST_COMB: begin
        // p0 = first cross product, p1 = second, prod = denominator product.
        case (kind_q)
          KIND_LOAD: begin
            ns_d = os_q;
            nm_d = {32'd0, on_q};
            dm_d = {32'd0, od_q};
          end
          KIND_ADD, KIND_SUB: begin
            if (as == (os_q ^ (kind_q == KIND_SUB))) begin
              ns_d = as;
              nm_d = p0_q + p1_q;
            end else if (p0_q >= p1_q) begin
              ns_d = as;
              nm_d = p0_q - p1_q;
            end else begin
              ns_d = os_q ^ (kind_q == KIND_SUB);
              nm_d = p1_q - p0_q;
            end
            dm_d = prod;
          end
          KIND_MUL: begin
            ns_d = as ^ os_q;
            nm_d = p0_q;
            dm_d = prod;
          end
          default: begin
            ns_d = as ^ os_q;
            nm_d = p0_q;
            dm_d = p1_q;
          end
        endcase
        state_d = ST_GCD;
      end
      ST_GCD: begin
        if (dm_q == '0) begin
          dm_d  = DW'(1);
          bad_d = 1'b1;
        end
        if (nm_q == '0) begin
          ns_d    = 1'b0;
          dm_d    = DW'(1);
          state_d = ST_FIT;
        end else begin
          ga_d    = nm_q;
          gb_d    = (dm_q == '0) ? DW'(1) : dm_q;
          state_d = ST_GWAIT;
          dctl.start = 1'b1;
          ddvd    = nm_q;
          ddvs    = (dm_q == '0) ? DW'(1) : dm_q;
        end
      end
      ST_GWAIT: begin
        if (dsts.done) begin
          if (dr == '0) begin
            // gb holds the divisor; nm/gb is the quotient just produced when ga==nm.
            state_d = ST_QN;
          end else begin
            ga_d = gb_q;
            gb_d = dr;
            dctl.start = 1'b1;
            ddvd = gb_q;
            ddvs = dr;
          end
        end
      end
      ST_QN: begin
        dctl.start = 1'b1;
        ddvd    = nm_q;
        ddvs    = gb_q;
        state_d = ST_QNW;
      end
      ST_QNW: begin
        if (dsts.done) begin
          nm_d = dq;
          dctl.start = 1'b1;
          ddvd    = dm_q;
          ddvs    = gb_q;
          state_d = ST_QDW;
        end
      end
      ST_QDW: begin
        if (dsts.done) begin
          dm_d    = dq;
          state_d = ST_FIT;
        end
      end
      ST_FIT: begin
        if (fits) begin
          accn_d = WIDTH'(ns_q ? -nm_q : nm_q);
          accd_d = WIDTH'(dm_q);
        end else begin
          ovf_d = 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mstep_q <= 2'd0;
      accn_q  <= '0;
      accd_q  <= WIDTH'(1);
      bad_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
      accn_q  <= accn_d;
      accd_q  <= accd_d;
      bad_q   <= bad_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_i.valid) begin
      kind_q <= req_i.data.kind;
      on_q   <= rn_mag;
      od_q   <= rd_zero ? 32'd1 : rd_mag;
      os_q   <= (rn_mag != 32'd0) && (rn_neg != (rd_neg && !rd_zero));
    end
    if (state_q == ST_MUL && mstep_q == 2'd0) p0_q <= p_d;
    if (state_q == ST_MUL && mstep_q == 2'd1) p1_q <= p_d;
    nm_q <= nm_d;
    dm_q <= dm_d;
    ns_q <= ns_d;
    ga_q <= ga_d;
    gb_q <= gb_d;
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = (state_q == ST_OUT);
  assign rsp_o.data.result_numerator   = 32'(signed'(accn_q));
  assign rsp_o.data.result_denominator = 31'(accd_q);
  assign rsp_o.data.bad_denominator    = bad_q;
  assign rsp_o.data.overflow           = ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(req_i.ready && rsp_o.valid))
    else $error("ready while a result is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni) accd_q != '0)
    else $error("held denominator is zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !accd_q[WIDTH-1])
    else $error("held denominator negative");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && ovf_q) |-> $stable(accn_q))
    else $error("overflow changed the state");

endmodule

FILE: sim/tb_rational_number_alu_core.sv
// Testbench for the rational accumulator core: drives random and directed requests,
// predicts each result in a local model and compares field by field.
// Depends on rna_pkg, rna_if and rational_number_alu_core.
module tb_rational_number_alu_core;
  import rna_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 60000;

  logic clk_i;
  logic rst_ni;

  rna_req_if req_if ();
  rna_rsp_if rsp_if ();

  rational_number_alu_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  req_t pending_q[$];
  rsp_t fraction_q[$];

  logic signed [63:0] held_num = 0;
  logic        [63:0] held_den = 1;

  int unsigned error_count = 0;
  int unsigned accepted_count = 0;
  int unsigned result_count = 0;
  int unsigned overflow_count = 0;
  int unsigned bad_den_count = 0;
  int unsigned idle_cycles = 0;
  bit          stimulus_done = 1'b0;
  bit          no_idling;
  int unsigned drv_gap;
  int unsigned mon_gap;
  int unsigned long_hold;
  bit          hold_armed;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Signed 32-bit field split into sign and magnitude.
  function automatic logic [63:0] magnitude(input logic [31:0] raw, output bit neg);
    neg = raw[31];
    return raw[31] ? 64'h1_0000_0000 - {32'd0, raw} : {32'd0, raw};
  endfunction

  function automatic logic [63:0] signed_sum(input bit s1, input logic [63:0] m1,
                                             input bit s2, input logic [63:0] m2,
                                             output bit rs);
    if (s1 == s2) begin
      rs = s1;
      return m1 + m2;
    end
    if (m1 >= m2) begin
      rs = s1;
      return m1 - m2;
    end
    rs = s2;
    return m2 - m1;
  endfunction

  // Advances the held fraction by one request and returns the reported fraction.
  function automatic rsp_t accumulate(input req_t r);
    rsp_t        res;
    bit          on_neg, od_neg, os, as, ns, bad, ovf;
    logic [63:0] on, od, am, ad, nm, dm, g, half;
    bad = 1'b0;
    ovf = 1'b0;
    if (r.kind <= KIND_DIV) begin
      on = magnitude(r.operand_numerator, on_neg);
      od = magnitude(r.operand_denominator, od_neg);
      if (od == 0) begin
        od = 1;
        od_neg = 1'b0;
        bad = 1'b1;
      end
      os = (on != 0) && (on_neg != od_neg);
      as = held_num < 0;
      am = as ? -held_num : held_num;
      ad = held_den;
      case (r.kind)
        KIND_LOAD: begin
          ns = os; nm = on; dm = od;
        end
        KIND_ADD: begin
          nm = signed_sum(as, am * od, os, on * ad, ns);
          dm = ad * od;
        end
        KIND_SUB: begin
          nm = signed_sum(as, am * od, !os, on * ad, ns);
          dm = ad * od;
        end
        KIND_MUL: begin
          ns = as != os; nm = am * on; dm = ad * od;
        end
        default: begin
          ns = as != os; nm = am * od; dm = ad * on;
        end
      endcase
      if (dm == 0) begin
        dm = 1;
        bad = 1'b1;
      end
      if (nm == 0) begin
        ns = 1'b0;
        dm = 1;
      end else begin
        g = gcd64(nm, dm);
        nm = nm / g;
        dm = dm / g;
      end
      half = 64'd1 << (WIDTH - 1);
      if ((dm <= half - 1) && (ns ? nm <= half : nm <= half - 1)) begin
        held_num = ns ? -$signed(nm) : $signed(nm);
        held_den = dm;
      end else begin
        ovf = 1'b1;
      end
    end
    res.result_numerator   = held_num[31:0];
    res.result_denominator = held_den[30:0];
    res.bad_denominator    = bad;
    res.overflow           = ovf;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at result %0d", what, got, want, result_count);
    error_count++;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 2000) - 1000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t make_req(input logic [2:0] k, input logic [31:0] n,
                                    input logic [31:0] d);
    req_t r;
    r.kind = k;
    r.operand_numerator = n;
    r.operand_denominator = d;
    return r;
  endfunction

  initial begin
    req_t r;
    // Directed: field extremes, every operation, zero denominators and numerators,
    // division by zero, negative denominators, overflow and undefined kinds.
    pending_q.push_back(make_req(KIND_ADD, 32'd1, 32'd2));
    pending_q.push_back(make_req(KIND_LOAD, 32'd6, 32'hFFFF_FFFC));
    pending_q.push_back(make_req(KIND_SUB, 32'd1, 32'd3));
    pending_q.push_back(make_req(KIND_MUL, 32'hFFFF_FFFD, 32'd7));
    pending_q.push_back(make_req(KIND_DIV, 32'd5, 32'hFFFF_FFFE));
    pending_q.push_back(make_req(KIND_DIV, 32'd0, 32'd3));
    pending_q.push_back(make_req(KIND_LOAD, 32'd9, 32'd0));
    pending_q.push_back(make_req(KIND_LOAD, 32'd0, 32'd0));
    pending_q.push_back(make_req(KIND_LOAD, 32'h8000_0000, 32'd1));
    pending_q.push_back(make_req(KIND_LOAD, 32'h8000_0000, 32'hFFFF_FFFF));
    pending_q.push_back(make_req(KIND_LOAD, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_q.push_back(make_req(KIND_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_q.push_back(make_req(KIND_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFE));
    pending_q.push_back(make_req(KIND_MUL, 32'h7FFF_FFFF, 32'd1));
    pending_q.push_back(make_req(KIND_ADD, 32'h7FFF_FFFF, 32'd1));
    pending_q.push_back(make_req(KIND_SUB, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(make_req(3'd5, 32'hFFFF_FFFF, 32'd0));
    pending_q.push_back(make_req(3'd6, 32'd1, 32'd1));
    pending_q.push_back(make_req(3'd7, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_q.push_back(make_req(KIND_LOAD, 32'd4, 32'd6));
    pending_q.push_back(make_req(KIND_MUL, 32'd0, 32'd0));
    pending_q.push_back(make_req(KIND_LOAD, 32'd2, 32'd3));
    pending_q.push_back(make_req(KIND_DIV, 32'd0, 32'd5));
    for (int i = 0; i < 1130; i++) begin
      if ($urandom_range(0, 19) == 0) r.kind = 3'($urandom_range(5, 7));
      else r.kind = 3'($urandom_range(0, 4));
      r.operand_numerator = rand_field();
      r.operand_denominator = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_field();
      pending_q.push_back(r);
    end
  end

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      drv_gap      <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        fraction_q.push_back(accumulate(req_if.data));
        accepted_count <= accepted_count + 1;
      end
      if (drv_gap != 0) begin
        drv_gap <= drv_gap - 1;
        req_if.valid <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 7) == 0) begin
        drv_gap <= $urandom_range(0, 2);
        req_if.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        req_if.data  <= pending_q.pop_front();
        req_if.valid <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // Result monitor; one long hold-off lets the sender back up against the block.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      mon_gap      <= 0;
      long_hold    <= 0;
      hold_armed   <= 1'b1;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (fraction_q.size() == 0) begin
          report_mismatch("unexpected result", rsp_if.data.result_numerator, 32'd0);
        end else begin
          want = fraction_q.pop_front();
          if (rsp_if.data.result_numerator !== want.result_numerator)
            report_mismatch("numerator", rsp_if.data.result_numerator,
                            want.result_numerator);
          if (rsp_if.data.result_denominator !== want.result_denominator)
            report_mismatch("denominator", {1'b0, rsp_if.data.result_denominator},
                            {1'b0, want.result_denominator});
          if (rsp_if.data.bad_denominator !== want.bad_denominator)
            report_mismatch("bad_denominator", {31'd0, rsp_if.data.bad_denominator},
                            {31'd0, want.bad_denominator});
          if (rsp_if.data.overflow !== want.overflow)
            report_mismatch("overflow", {31'd0, rsp_if.data.overflow},
                            {31'd0, want.overflow});
          if (want.overflow) overflow_count++;
          if (want.bad_denominator) bad_den_count++;
        end
        result_count++;
      end
      if (hold_armed && result_count == 40) begin
        hold_armed   <= 1'b0;
        long_hold    <= 3000;
        rsp_if.ready <= 1'b0;
      end else if (long_hold != 0) begin
        long_hold    <= long_hold - 1;
        rsp_if.ready <= (long_hold == 1);
      end else if (mon_gap != 0) begin
        mon_gap      <= mon_gap - 1;
        rsp_if.ready <= (mon_gap == 1);
      end else if (!no_idling && $urandom_range(0, 7) == 0) begin
        mon_gap      <= $urandom_range(0, 2);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        long_hold != 0) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired: %0d results outstanding", fraction_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    no_idling = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() < 100);
    no_idling = 1'b1;
    wait (stimulus_done && fraction_q.size() == 0);
    repeat (600) @(posedge clk_i);
    $display("Covered %0d requests and %0d results across load, add, subtract,",
             accepted_count, result_count);
    $display("multiply, divide and undefined kinds; %0d overflows, %0d zero denominators.",
             overflow_count, bad_den_count);
    if (error_count == 0 && fraction_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
